[rtl/svr_pkg.sv]
// shared types, constants and sample decode for the sample playback voice
// no dependencies
package svr_pkg;

  localparam int MAX_FRAMES = 65536;
  localparam int ADDR_W     = $clog2(MAX_FRAMES);
  localparam int POS_W      = 29;
  localparam int FRAC_W     = 12;
  localparam int FC_W       = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int FC_CAP     = (MAX_FRAMES < 65536) ? MAX_FRAMES : 65536;
  localparam int FC_MIN     = 3;
  localparam int UNITY      = 4096;

  localparam logic [POS_W-1:0] LOOP_END_RST = POS_W'((FC_CAP - 2) * UNITY);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEREO_MODE   = 3'd0,
    REG_SAMPLE_FORMAT = 3'd1,
    REG_FRAME_COUNT   = 3'd2,
    REG_STEP          = 3'd3,
    REG_LEFT_VOLUME   = 3'd4,
    REG_RIGHT_VOLUME  = 3'd5,
    REG_PLAY_COUNT    = 3'd6
  } reg_idx_t;

  typedef enum logic {
    FMT_S16 = 1'b0,
    FMT_U8  = 1'b1
  } sample_fmt_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef struct packed {
    logic              stereo_mode;
    logic              sample_format;
    logic [POS_W-1:0]  loop_end;
    logic [15:0]       step_increment;
    logic [12:0]       left_volume;
    logic [12:0]       right_volume;
    logic [7:0]        play_count;
  } cfg_t;

  typedef struct packed {
    logic cap_s0;
    logic mul_frac;
    logic mul_vol;
  } lane_ctl_t;

  function automatic logic signed [15:0] decode_word(logic [15:0] w, logic fmt);
    logic signed [15:0] r;
    if (sample_fmt_t'(fmt) == FMT_U8) begin
      r = $signed({~w[7], w[6:0], 8'h00});
    end else begin
      r = $signed(w);
    end
    return r;
  endfunction

endpackage

[rtl/svr_ram.sv]
// generic single write, single read port ram with registered read data
// no dependencies
module svr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/svr_cfg.sv]
// configuration registers; frame count is kept as a clamped Q12 loop end
// depends on svr_pkg
module svr_cfg
  import svr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [FC_W-1:0]  fc_lo;
  logic [FC_W-1:0]  fc_clamped;
  logic [POS_W-1:0] loop_end_next;

  always_comb begin
    fc_lo = (cfg_data[FC_W-1:0] < FC_W'(FC_MIN)) ? FC_W'(FC_MIN) : cfg_data[FC_W-1:0];
    fc_clamped = (fc_lo > FC_W'(FC_CAP)) ? FC_W'(FC_CAP) : fc_lo;
    loop_end_next = POS_W'(fc_clamped - FC_W'(2)) << FRAC_W;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stereo_mode    <= 1'b0;
      cfg.sample_format  <= 1'b0;
      cfg.loop_end       <= LOOP_END_RST;
      cfg.step_increment <= 16'd4096;
      cfg.left_volume    <= 13'd4096;
      cfg.right_volume   <= 13'd4096;
      cfg.play_count     <= 8'd1;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEREO_MODE:   cfg.stereo_mode    <= cfg_data[0];
        REG_SAMPLE_FORMAT: cfg.sample_format  <= cfg_data[0];
        REG_FRAME_COUNT:   cfg.loop_end       <= loop_end_next;
        REG_STEP:          cfg.step_increment <= cfg_data[15:0];
        REG_LEFT_VOLUME:   cfg.left_volume    <= cfg_data[12:0];
        REG_RIGHT_VOLUME:  cfg.right_volume   <= cfg_data[12:0];
        REG_PLAY_COUNT:    cfg.play_count     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/svr_lane.sv]
// one output side: decode, linear interpolation, volume scale, saturation
// depends on svr_pkg
module svr_lane
  import svr_pkg::*;
(
  input  logic               clk,
  input  lane_ctl_t          ctl,
  input  logic               sample_format,
  input  logic [15:0]        rdata,
  input  logic [FRAC_W-1:0]  frac,
  input  logic [12:0]        volume,
  output logic signed [15:0] sample
);

  logic signed [15:0] s0;
  logic signed [15:0] s1;
  logic signed [16:0] diff;
  logic signed [29:0] prod_c;
  logic signed [29:0] prod;
  logic signed [17:0] interp;
  logic signed [31:0] scaled_c;
  logic signed [31:0] scaled;
  logic signed [19:0] shifted;

  always_comb begin
    s1 = decode_word(rdata, sample_format);
    diff = {s1[15], s1} - {s0[15], s0};
    prod_c = diff * $signed({1'b0, frac});
    interp = $signed(prod[29:12]) + 18'(s0);
    scaled_c = interp * $signed({1'b0, volume});
    shifted = scaled[31:12];
    if (shifted > 20'sd32767) begin
      sample = 16'sh7fff;
    end else if (shifted < -20'sd32768) begin
      sample = -16'sh8000;
    end else begin
      sample = shifted[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_s0) begin
      s0 <= s1;
    end
    if (ctl.mul_frac) begin
      prod <= prod_c;
    end
    if (ctl.mul_vol) begin
      scaled <= scaled_c;
    end
  end

endmodule

[rtl/sample_voice_resampler.sv]
// sample playback voice: a load is written in the cycle it is accepted, back to back;
// a tick passes states RD2, MUL1, MUL2 and OUT before it shows on the output (two reads
// of the neighboring frames through the single read port, interpolation multiply, volume
// multiply, saturate) and the next item is taken only after that, later while a stalled
// output item still waits; a stopped voice goes from acceptance straight to OUT
// reset: config to defaults, position and pass count zero, output empty; ram not cleared
module sample_voice_resampler
  import svr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  logic [15:0]           load_frame,
  input  logic                  load_channel,
  input  logic [15:0]           load_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    left_sample,
  output logic signed [15:0]    right_sample,
  output logic                  finished
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD2,
    ST_MUL1,
    ST_MUL2,
    ST_OUT
  } state_t;

  state_t state;

  cfg_t cfg;

  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  start_pos;
  logic [POS_W-1:0]  start_c;
  logic [POS_W-1:0]  pos_sum;
  logic [7:0]        passes_done;
  logic [7:0]        passes_inc;
  logic              stopped;
  logic              wrap_flag;
  logic              item_stopped;

  logic              in_accept;
  logic              load_ok;
  logic [ADDR_W-1:0] raddr;
  logic              we0;
  logic              we1;
  logic [15:0]       rdata0;
  logic [15:0]       rdata1;
  logic [15:0]       rdata_r;

  lane_ctl_t          ctl;
  logic signed [15:0] left_c;
  logic signed [15:0] right_c;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_ok   = (32'(load_frame) < MAX_FRAMES);
  assign we0 = in_accept && (action_t'(action) == ACT_LOAD) && load_ok && !load_channel;
  assign we1 = in_accept && (action_t'(action) == ACT_LOAD) && load_ok && load_channel;
  assign start_c = (position >= cfg.loop_end) ? '0 : position;
  assign passes_inc = passes_done + 8'd1;
  assign rdata_r = cfg.stereo_mode ? rdata1 : rdata0;

  always_comb begin
    if (state == ST_RD2) begin
      raddr = ADDR_W'(start_pos[POS_W-1:FRAC_W] + 17'd1);
    end else begin
      raddr = ADDR_W'(start_c[POS_W-1:FRAC_W]);
    end
    ctl.cap_s0   = (state == ST_RD2);
    ctl.mul_frac = (state == ST_MUL1);
    ctl.mul_vol  = (state == ST_MUL2);
  end

  svr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  svr_ram #(.WIDTH(16), .DEPTH(MAX_FRAMES)) u_ram_ch0 (
    .clk   (clk),
    .we    (we0),
    .waddr (ADDR_W'(load_frame)),
    .wdata (load_value),
    .raddr (raddr),
    .rdata (rdata0)
  );

  svr_ram #(.WIDTH(16), .DEPTH(MAX_FRAMES)) u_ram_ch1 (
    .clk   (clk),
    .we    (we1),
    .waddr (ADDR_W'(load_frame)),
    .wdata (load_value),
    .raddr (raddr),
    .rdata (rdata1)
  );

  svr_lane u_lane_left (
    .clk           (clk),
    .ctl           (ctl),
    .sample_format (cfg.sample_format),
    .rdata         (rdata0),
    .frac          (start_pos[FRAC_W-1:0]),
    .volume        (cfg.left_volume),
    .sample        (left_c)
  );

  svr_lane u_lane_right (
    .clk           (clk),
    .ctl           (ctl),
    .sample_format (cfg.sample_format),
    .rdata         (rdata_r),
    .frac          (start_pos[FRAC_W-1:0]),
    .volume        (cfg.right_volume),
    .sample        (right_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      position     <= '0;
      passes_done  <= '0;
      stopped      <= 1'b0;
      out_valid    <= 1'b0;
      wrap_flag    <= 1'b0;
      item_stopped <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept && action_t'(action) == ACT_TICK) begin
            item_stopped <= stopped;
            start_pos    <= start_c;
            state        <= stopped ? ST_OUT : ST_RD2;
          end
        end
        ST_RD2: begin
          pos_sum <= start_pos + POS_W'(cfg.step_increment);
          state   <= ST_MUL1;
        end
        ST_MUL1: begin
          wrap_flag <= (pos_sum >= cfg.loop_end);
          position  <= (pos_sum >= cfg.loop_end) ? pos_sum - cfg.loop_end : pos_sum;
          state     <= ST_MUL2;
        end
        ST_MUL2: begin
          if (wrap_flag) begin
            if (position >= cfg.loop_end) begin
              position <= '0;
            end
            if (cfg.play_count != 8'd0) begin
              passes_done <= passes_inc;
              if (passes_inc >= cfg.play_count) begin
                stopped <= 1'b1;
              end
            end
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (item_stopped) begin
              left_sample  <= '0;
              right_sample <= '0;
              finished     <= 1'b1;
            end else begin
              left_sample  <= left_c;
              right_sample <= right_c;
              finished     <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/svr_check.sv]
// port-level checks for the sample playback voice, bound to the top level
// depends on sample_voice_resampler ports only
module svr_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               action,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] left_sample,
  input logic signed [15:0] right_sample,
  input logic               finished
);

  logic seen_finished;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_finished <= 1'b0;
    end else if (out_valid && !out_stall && finished) begin
      seen_finished <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(left_sample)
      && $stable(right_sample) && $stable(finished))
    else $error("stalled output item changed");

  a_finished_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> left_sample == 16'sd0 && right_sample == 16'sd0)
    else $error("finished item carries nonzero samples");

  a_finished_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_finished |-> finished)
    else $error("voice resumed after finishing");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action |=> in_stall)
    else $error("tick did not occupy the voice");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output item present right after reset");

endmodule

bind sample_voice_resampler svr_check u_svr_check (.*);

[dv/tb_sample_voice_resampler.sv]
// self-checking testbench for the sample playback voice: loads pcm words, ticks frames
// and checks every output frame against an in-bench voice predictor
// depends on rtl/svr_pkg.sv and rtl/sample_voice_resampler.sv
module tb_sample_voice_resampler;
  import svr_pkg::*;

  localparam int RANDOM_ITEMS  = 1900;
  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;

  typedef struct {
    action_t            act;
    logic [15:0]        frame;
    logic               ch;
    logic [15:0]        value;
    bit                 has_result;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               fin;
  } voice_item_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               fin;
  } stereo_frame_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  action = 1'b0;
  logic [15:0]           load_frame = '0;
  logic                  load_channel = 1'b0;
  logic [15:0]           load_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [15:0]    left_sample;
  logic signed [15:0]    right_sample;
  logic                  finished;

  sample_voice_resampler dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  voice_item_t   pending_items[$];
  stereo_frame_t expected_frames[$];
  voice_item_t   cur_item;
  logic          in_taken = 1'b0;

  // voice predictor state
  bit          cfg_stereo = 1'b0;
  sample_fmt_t cfg_format = FMT_S16;
  int          cfg_frames = 65536;
  int          cfg_step = 4096;
  int          cfg_lvol = 4096;
  int          cfg_rvol = 4096;
  int          cfg_plays = 1;
  int          play_pos = 0;
  logic [7:0]  passes_done = '0;
  bit          voice_stopped = 1'b0;
  logic [15:0] pcm_words [0:1][0:65535];
  bit          pcm_loaded [0:1][0:65535];

  int send_idle_pct = 10;
  int recv_idle_pct = 54;
  int hold_left = 0;
  int error_count = 0;
  int frames_checked = 0;
  int silent_frames = 0;
  int loads_made = 0;
  int ticks_made = 0;
  int phase_count = 0;
  int quiet_cycles = 0;

  function automatic int loop_frames();
    int fc;
    fc = cfg_frames;
    if (fc < FC_MIN) fc = FC_MIN;
    if (fc > MAX_FRAMES) fc = MAX_FRAMES;
    return fc;
  endfunction

  function automatic int pcm_sample(bit ch, int frame);
    logic [15:0] w;
    w = pcm_words[ch][frame];
    if (cfg_format == FMT_U8) return (int'(w[7:0]) - 128) * 256;
    return int'($signed(w));
  endfunction

  function automatic int blend(bit ch, int p, int f);
    longint mix;
    mix = longint'(pcm_sample(ch, p)) * longint'(UNITY - f)
        + longint'(pcm_sample(ch, p + 1)) * longint'(f);
    return int'(mix >>> 12);
  endfunction

  function automatic logic signed [15:0] apply_gain(int v, int vol);
    longint r;
    r = (longint'(v) * longint'(vol)) >>> 12;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic queue_load(int frame, bit ch, logic [15:0] value);
    voice_item_t it;
    it.act = ACT_LOAD;
    it.frame = frame[15:0];
    it.ch = ch;
    it.value = value;
    it.has_result = 1'b0;
    it.left = '0;
    it.right = '0;
    it.fin = 1'b0;
    pcm_words[ch][frame] = value;
    pcm_loaded[ch][frame] = 1'b1;
    pending_items.push_back(it);
    loads_made++;
  endtask

  task automatic need_word(bit ch, int frame);
    if (!pcm_loaded[ch][frame]) queue_load(frame, ch, 16'($urandom));
  endtask

  task automatic plan_tick();
    voice_item_t it;
    int loop_end, p, f, lv, rv;
    it.act = ACT_TICK;
    it.frame = 16'($urandom);
    it.ch = 1'($urandom);
    it.value = 16'($urandom);
    it.has_result = 1'b1;
    if (voice_stopped) begin
      it.left = '0;
      it.right = '0;
      it.fin = 1'b1;
    end else begin
      loop_end = (loop_frames() - 2) << FRAC_W;
      if (play_pos >= loop_end) play_pos = 0;
      p = play_pos >> FRAC_W;
      f = play_pos & (UNITY - 1);
      // never read a word that was not loaded
      need_word(1'b0, p);
      need_word(1'b0, p + 1);
      if (cfg_stereo) begin
        need_word(1'b1, p);
        need_word(1'b1, p + 1);
      end
      lv = blend(1'b0, p, f);
      rv = cfg_stereo ? blend(1'b1, p, f) : lv;
      it.left = apply_gain(lv, cfg_lvol);
      it.right = apply_gain(rv, cfg_rvol);
      it.fin = 1'b0;
      play_pos += cfg_step;
      if (play_pos >= loop_end) begin
        play_pos -= loop_end;
        if (play_pos >= loop_end) play_pos = 0;
        if (cfg_plays != 0) begin
          passes_done++;
          if (int'(passes_done) >= cfg_plays) voice_stopped = 1'b1;
        end
      end
      play_pos &= 32'h1FFF_FFFF;
    end
    pending_items.push_back(it);
    ticks_made++;
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
  endtask

  task automatic apply_settings(bit stereo, sample_fmt_t fmt, int unsigned frames,
                                int unsigned step, int unsigned lvol, int unsigned rvol,
                                int unsigned plays);
    write_reg(REG_STEREO_MODE, stereo);
    write_reg(REG_SAMPLE_FORMAT, fmt);
    write_reg(REG_FRAME_COUNT, frames);
    write_reg(REG_STEP, step);
    write_reg(REG_LEFT_VOLUME, lvol);
    write_reg(REG_RIGHT_VOLUME, rvol);
    write_reg(REG_PLAY_COUNT, plays);
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_stereo = stereo;
    cfg_format = fmt;
    cfg_frames = frames & 'h1FFFF;
    cfg_step = step & 'hFFFF;
    cfg_lvol = lvol & 'h1FFF;
    cfg_rvol = rvol & 'h1FFF;
    cfg_plays = plays & 'hFF;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_frames.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(bit stereo, sample_fmt_t fmt, int unsigned frames,
                           int unsigned step, int unsigned lvol, int unsigned rvol,
                           int unsigned plays, int ticks, int noise_pct);
    int span;
    wait_drained();
    apply_settings(stereo, fmt, frames, step, lvol, rvol, plays);
    phase_count++;
    span = loop_frames();
    for (int t = 0; t < ticks; t++) begin
      if ($urandom_range(99) < noise_pct) begin
        if ($urandom_range(1))
          queue_load($urandom_range(span - 1, 0), 1'($urandom), 16'($urandom));
        else
          queue_load($urandom_range(65535, 0), 1'($urandom), 16'($urandom));
      end
      plan_tick();
    end
  endtask

  function automatic int unsigned pick_volume();
    case ($urandom_range(4))
      0: return 0;
      1: return 8191;
      2: return UNITY;
      default: return $urandom_range(8191, 0);
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_item = pending_items.pop_front();
        in_valid <= 1'b1;
        action <= cur_item.act;
        load_frame <= cur_item.frame;
        load_channel <= cur_item.ch;
        load_value <= cur_item.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls, with a single long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  // monitor
  always @(posedge clk) begin
    stereo_frame_t exp_frame;
    in_taken <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall && cur_item.has_result) begin
      exp_frame.left = cur_item.left;
      exp_frame.right = cur_item.right;
      exp_frame.fin = cur_item.fin;
      expected_frames.push_back(exp_frame);
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        flag_error($sformatf("unexpected frame: got %0d/%0d fin %0b",
                             left_sample, right_sample, finished));
      end else begin
        exp_frame = expected_frames.pop_front();
        if (left_sample !== exp_frame.left || right_sample !== exp_frame.right ||
            finished !== exp_frame.fin)
          flag_error($sformatf("frame %0d: expected %0d/%0d fin %0b, got %0d/%0d fin %0b",
                               frames_checked, exp_frame.left, exp_frame.right,
                               exp_frame.fin, left_sample, right_sample, finished));
        if (exp_frame.fin) silent_frames++;
        frames_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_sample_voice_resampler: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned frames, step, plays;
    int ticks, random_start, made;
    bit pressed;
    pressed = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: reset settings, sample extremes, saturation, u8, odd frame counts
    queue_load(0, 1'b0, 16'h7FFF);
    queue_load(1, 1'b0, 16'h8000);
    queue_load(2, 1'b0, 16'h0000);
    queue_load(0, 1'b1, 16'h80FF);
    queue_load(1, 1'b1, 16'h7F00);
    queue_load(65535, 1'b1, 16'hFFFF);
    plan_tick();
    plan_tick();
    phase_count++;
    run_phase(1'b1, FMT_S16, 3, 2048, 8191, 0, 0, 4, 0);
    run_phase(1'b1, FMT_U8, 0, 65535, UNITY, UNITY, 0, 3, 0);
    run_phase(1'b0, FMT_U8, 131071, 65535, 0, 8191, 0, 2, 0);
    run_phase(1'b0, FMT_S16, 3, 0, 8191, 8191, 0, 3, 0);

    random_start = loads_made + ticks_made;
    made = 0;
    while (made < RANDOM_ITEMS) begin
      if (made < RANDOM_ITEMS / 3) begin
        send_idle_pct = 10;
        recv_idle_pct = 54;
      end else if (made < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      ticks = $urandom_range(60, 20);
      case ($urandom_range(19))
        0: frames = $urandom_range(2, 0);
        1: frames = $urandom_range(131071, 65537);
        2, 3: frames = 65536;
        4, 5: frames = $urandom_range(2000, 41);
        default: frames = $urandom_range(40, 3);
      endcase
      case ($urandom_range(9))
        0: step = 0;
        1: step = 1;
        2: step = 65535;
        3, 4: step = $urandom_range(65535, 1);
        default: step = $urandom_range(12288, 1);
      endcase
      // pass counting only where it cannot stop the voice yet
      plays = 0;
      if ($urandom_range(3) == 0 && int'(passes_done) + ticks < 255)
        plays = $urandom_range(255, int'(passes_done) + ticks + 1);
      run_phase(1'($urandom), sample_fmt_t'($urandom_range(1)), frames, step,
                pick_volume(), pick_volume(), plays, ticks, 30);
      if (!pressed) begin
        pressed = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      made = loads_made + ticks_made - random_start;
    end

    // last pass: let the voice stop, then tick and load on a stopped voice
    send_idle_pct = 10;
    recv_idle_pct = 54;
    plays = (int'(passes_done) + 3 > 255) ? 255 : int'(passes_done) + 3;
    run_phase(1'($urandom), FMT_S16, 3, 4096, UNITY, UNITY, plays, 12, 40);
    wait_drained();

    $display("covered %0d items in %0d setting phases: %0d loads, %0d ticks",
             loads_made + ticks_made, phase_count, loads_made, ticks_made);
    $display("compared %0d frames, %0d of them after the voice stopped; %0d failures",
             frames_checked, silent_frames, error_count);
    if (error_count == 0 && expected_frames.size() == 0)
      $display("tb_sample_voice_resampler: done, clean");
    else
      $display("tb_sample_voice_resampler: done, errors");
    $finish;
  end

endmodule
